FILE: hdl/pbw_pkg.sv
// Package for the periodic boundary wrap block: widths, register codes,
// reset values and the per-axis result struct. No dependencies.
package pbw_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int LEN_W       = 30;
    localparam int MASK_W      = 3;
    localparam int AXES        = 3;
    localparam int CFG_IDX_W   = 2;

    // Working width: holds a sign-extended coordinate and three box lengths.
    localparam int EXT_W = ((COORD_WIDTH > LEN_W + 1) ? COORD_WIDTH : LEN_W + 1) + 2;

    localparam logic [LEN_W-1:0]  BOX_LEN_RESET  = LEN_W'(1048576);
    localparam logic [MASK_W-1:0] PER_MASK_RESET = MASK_W'(7);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [LEN_W-1:0]              len_t;
    typedef logic [MASK_W-1:0]             per_mask_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_LEN_X,
        REG_BOX_LEN_Y,
        REG_BOX_LEN_Z,
        REG_PERIODIC_MASK
    } cfg_reg_t;

    typedef struct packed {
        coord_t disp;
        coord_t fold;
        logic   err;
        logic   outside;
    } pbw_axis_res_t;

endpackage

FILE: hdl/pbw_coord_if.sv
// Input channel of the periodic boundary wrap block: one 3D coordinate per item.
// Depends on pbw_pkg.
interface pbw_coord_if import pbw_pkg::*;;
    logic   valid;
    logic   ready;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

FILE: hdl/pbw_result_if.sv
// Result channel of the periodic boundary wrap block: displacement, folded
// position and flags per item. Depends on pbw_pkg.
interface pbw_result_if import pbw_pkg::*;;
    logic   valid;
    logic   ready;
    coord_t disp_x;
    coord_t disp_y;
    coord_t disp_z;
    coord_t fold_x;
    coord_t fold_y;
    coord_t fold_z;
    logic   inside_res;
    logic   range_error;

    modport source (
        output valid, output disp_x, output disp_y, output disp_z,
        output fold_x, output fold_y, output fold_z,
        output inside_res, output range_error, input ready
    );
    modport sink (
        input valid, input disp_x, input disp_y, input disp_z,
        input fold_x, input fold_y, input fold_z,
        input inside_res, input range_error, output ready
    );
endinterface

FILE: hdl/pbw_axis.sv
// Single-axis minimum-image and fold logic, purely combinational.
// Depends on pbw_pkg.
module pbw_axis import pbw_pkg::*;
(
    input  coord_t        pos,
    input  len_t          len,
    input  logic          periodic,
    output pbw_axis_res_t res
);

    logic signed [EXT_W-1:0] v_e;
    logic signed [EXT_W-1:0] nv_e;
    logic signed [EXT_W-1:0] len_e;
    logic signed [EXT_W-1:0] len2_e;
    logic signed [EXT_W-1:0] half_e;
    logic signed [EXT_W-1:0] half3_e;
    logic signed [EXT_W-1:0] d_e;
    logic signed [EXT_W-1:0] f_e;
    logic                    d_err;
    logic                    f_err;

    assign v_e     = {{(EXT_W-COORD_WIDTH){pos[COORD_WIDTH-1]}}, pos};
    // -(v + 1) is the bitwise complement, which cannot overflow.
    assign nv_e    = ~v_e;
    assign len_e   = {{(EXT_W-LEN_W){1'b0}}, len};
    assign len2_e  = len_e <<< 1;
    assign half_e  = len_e >>> 1;
    assign half3_e = (len_e + len2_e) >>> 1;

    always_comb
    begin
        d_e   = v_e;
        d_err = 1'b0;
        if (v_e > half_e)
        begin
            d_e   = v_e - len_e;
            d_err = (v_e > half3_e);
        end
        else if (nv_e >= half_e)
        begin
            d_e   = v_e + len_e;
            d_err = (nv_e >= half3_e);
        end
    end

    always_comb
    begin
        f_e   = v_e;
        f_err = 1'b0;
        if (v_e < 0)
        begin
            f_e   = v_e + len_e;
            f_err = (v_e < -len_e);
        end
        else if (v_e >= len_e)
        begin
            f_e   = v_e - len_e;
            f_err = (v_e >= len2_e);
        end
    end

    always_comb
    begin
        if (periodic)
        begin
            res.disp    = d_e[COORD_WIDTH-1:0];
            res.fold    = f_e[COORD_WIDTH-1:0];
            res.err     = d_err | f_err;
            res.outside = 1'b0;
        end
        else
        begin
            res.disp    = pos;
            res.fold    = pos;
            res.err     = 1'b0;
            res.outside = (v_e < 0) || (v_e >= len_e);
        end
    end

endmodule

FILE: hdl/periodic_boundary_wrap_core.sv
// Top level of the periodic boundary wrap block: configuration registers,
// input register, three axis units and the result register.
// Depends on pbw_pkg, pbw_coord_if, pbw_result_if and pbw_axis.
//
//  channel   direction  payload
//  coord     in         pos_x, pos_y, pos_z
//  result    out        disp_x..z, fold_x..z, inside_res, range_error
//  cfg       in         cfg_we, cfg_index, cfg_wdata (write only)
//
// One item per cycle sustained while the result is taken; an accepted item
// passes through the input register and then the result register.
// Reset loads the box lengths with 1048576 and marks all axes periodic.
// A stalled result holds in the result register while one more item waits
// in the input register; ready drops only when both are full and the result
// is not taken.
module periodic_boundary_wrap_core import pbw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,
    pbw_coord_if.sink            coord,
    pbw_result_if.source         result
);

    len_t          box_len_reg [AXES];
    per_mask_t     per_mask_reg;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    coord_t        s1_pos_reg [AXES];
    logic          s2_valid_reg;
    logic          s2_valid_next;
    pbw_axis_res_t s2_res_reg [AXES];

    pbw_axis_res_t axis_res [AXES];
    logic          coord_acc;
    logic          s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_len_reg[0] <= BOX_LEN_RESET;
            box_len_reg[1] <= BOX_LEN_RESET;
            box_len_reg[2] <= BOX_LEN_RESET;
            per_mask_reg   <= PER_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BOX_LEN_X:     box_len_reg[0] <= cfg_wdata;
                REG_BOX_LEN_Y:     box_len_reg[1] <= cfg_wdata;
                REG_BOX_LEN_Z:     box_len_reg[2] <= cfg_wdata;
                REG_PERIODIC_MASK: per_mask_reg   <= cfg_wdata[MASK_W-1:0];
                default:           per_mask_reg   <= per_mask_reg;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or draining.
    assign s1_adv      = !s2_valid_reg || result.ready;
    assign coord.ready = !s1_valid_reg || s1_adv;
    assign coord_acc   = coord.valid && coord.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (coord_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        s2_valid_next = s1_adv ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coord_acc)
        begin
            s1_pos_reg[0] <= coord.pos_x;
            s1_pos_reg[1] <= coord.pos_y;
            s1_pos_reg[2] <= coord.pos_z;
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        pbw_axis u_axis
        (
            .pos      (s1_pos_reg[a]),
            .len      (box_len_reg[a]),
            .periodic (per_mask_reg[a]),
            .res      (axis_res[a])
        );

        always_ff @(posedge clk)
        begin
            if (s1_adv)
                s2_res_reg[a] <= axis_res[a];
        end
    end

    assign result.valid       = s2_valid_reg;
    assign result.disp_x      = s2_res_reg[0].disp;
    assign result.disp_y      = s2_res_reg[1].disp;
    assign result.disp_z      = s2_res_reg[2].disp;
    assign result.fold_x      = s2_res_reg[0].fold;
    assign result.fold_y      = s2_res_reg[1].fold;
    assign result.fold_z      = s2_res_reg[2].fold;
    assign result.inside_res  = !(s2_res_reg[0].outside || s2_res_reg[1].outside
                                  || s2_res_reg[2].outside);
    assign result.range_error = s2_res_reg[0].err || s2_res_reg[1].err
                                || s2_res_reg[2].err;

    // A waiting item in the input register is never dropped during a stall.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("input register lost an item while stalled");

    // An empty input register always takes a new item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> coord.ready)
        else $error("input not ready while input register empty");

    // A result appears only after an item sat in the input register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg))
        else $error("result valid without a pending item");

    // A non-periodic x axis passes the coordinate through without a range error.
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !per_mask_reg[0] |-> (axis_res[0].disp == s1_pos_reg[0])
                             && (axis_res[0].fold == s1_pos_reg[0]) && !axis_res[0].err)
        else $error("non-periodic x axis altered the coordinate");

endmodule
